// ===== rtl/core/sobel_prewitt_gradient_magnitude_unit_assert.svh =====
// assertion macros for the gradient magnitude unit checker
`ifndef SOBEL_PREWITT_GRADIENT_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_PREWITT_GRADIENT_MAGNITUDE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SPGM_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spgm checker: implication failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SPGM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spgm checker: next-cycle implication failed");

`endif

// ===== rtl/core/spgm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, register indexes and constants of the gradient magnitude unit
package spgm_pkg;

	localparam int PIXEL_W      = 8;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 13;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int GRAD_W       = 11;
	localparam int SQ_W         = 20;
	localparam int SUM_W        = 21;
	localparam int ROOT_BIT_W   = 3;

	localparam logic [SUM_W-1:0]        SAT_LIMIT    = 21'd65280;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KERNEL_SELECT = 2'd0,
		REG_IMAGE_WIDTH   = 2'd1,
		REG_IMAGE_HEIGHT  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KERNEL_SOBEL   = 1'b0,
		KERNEL_PREWITT = 1'b1
	} kernel_t;

	typedef enum logic {
		MODE_PIXEL = 1'b0,
		MODE_DRAIN = 1'b1
	} mode_t;

	typedef struct packed {
		logic               mode;
		logic [PIXEL_W-1:0] pixel;
	} in_item_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] magnitude;
		logic               end_of_row;
		logic               end_of_frame;
	} out_item_t;

	typedef struct packed {
		logic                  capture;
		logic                  drain;
		logic                  step;
		logic                  pre;
		logic                  top_refl;
		logic                  bot_refl;
		logic                  left_refl;
		logic                  prewitt;
		logic                  square;
		logic                  sum;
		logic                  root;
		logic [ROOT_BIT_W-1:0] root_bit;
		logic                  load_out;
		logic                  end_of_row;
		logic                  end_of_frame;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

// ===== rtl/core/spgm_ctrl.sv =====
`timescale 1ns / 1ps
// controller: raster counters, configuration registers and sequencing state machine
module spgm_ctrl import spgm_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int ROW_W = $clog2(MAX_HEIGHT + 2)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic                   item_mode,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic [COL_W-1:0]       col,
	output dp_cmd_t                cmd,
	input  dp_sts_t                sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_MUL,
		ST_SUM,
		ST_ROOT,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic                    kernel_q;
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic                    pre_q;
	logic                    produce_q;
	logic                    top_q;
	logic                    bot_q;
	logic                    left_q;
	logic                    eor_q;
	logic                    eof_q;
	logic [ROOT_BIT_W-1:0]   bit_q;

	logic [COL_W:0]   eff_w;
	logic [ROW_W-1:0] eff_h;
	logic [COL_W-1:0] w_m1;
	logic [ROW_W-1:0] h_m1;
	logic             drain_pos;
	logic             ignore;
	logic             accept;
	logic             pre;
	logic             post;
	logic             frame_end;
	logic [ROW_W-1:0] row_out;
	logic [COL_W-1:0] col_out;
	logic [COL_W:0]   col_inc;

	// clamp frame size to the supported range
	always_comb begin
		int w_lim;
		int h_lim;
		w_lim = int'(width_q);
		h_lim = int'(height_q);
		if (w_lim < 2) w_lim = 2;
		if (w_lim > MAX_WIDTH) w_lim = MAX_WIDTH;
		if (h_lim < 2) h_lim = 2;
		if (h_lim > MAX_HEIGHT) h_lim = MAX_HEIGHT;
		eff_w = (COL_W+1)'(w_lim);
		eff_h = ROW_W'(h_lim);
	end

	always_comb begin
		w_m1      = COL_W'(eff_w - 1'b1);
		h_m1      = ROW_W'(eff_h - 1'b1);
		item_ready = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
		accept    = item_valid && item_ready;
		drain_pos = (row_q >= eff_h);
		ignore    = !drain_pos && (item_mode == MODE_DRAIN);
		pre       = (col_q == '0) && (row_q >= ROW_W'(2));
		post      = (col_q != '0) && (row_q != '0);
		frame_end = (row_q > eff_h);
		row_out   = pre ? ROW_W'(row_q - ROW_W'(2)) : ROW_W'(row_q - 1'b1);
		col_out   = pre ? w_m1 : COL_W'(col_q - 1'b1);
		col_inc   = {1'b0, col_q} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			kernel_q  <= KERNEL_SOBEL;
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
			pre_q     <= 1'b0;
			produce_q <= 1'b0;
			top_q     <= 1'b0;
			bot_q     <= 1'b0;
			left_q    <= 1'b0;
			eor_q     <= 1'b0;
			eof_q     <= 1'b0;
			bit_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && !ignore) begin
						pre_q     <= pre;
						produce_q <= pre || post;
						top_q     <= (row_out == '0);
						bot_q     <= (row_out == h_m1);
						left_q    <= (col_out == '0);
						eor_q     <= (col_out == w_m1);
						eof_q     <= (col_out == w_m1) && (row_out == h_m1);
						if (frame_end) begin
							col_q <= '0;
							row_q <= '0;
						end else if (col_inc >= eff_w) begin
							col_q <= '0;
							row_q <= ROW_W'(row_q + 1'b1);
						end else begin
							col_q <= col_inc[COL_W-1:0];
						end
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					state_q <= produce_q ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					bit_q   <= '1;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (bit_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KERNEL_SELECT: begin
						kernel_q <= cfg_data[0];
					end
					REG_IMAGE_WIDTH: begin
						width_q <= cfg_data[WIDTH_REG_W-1:0];
						col_q   <= '0;
						row_q   <= '0;
					end
					REG_IMAGE_HEIGHT: begin
						height_q <= cfg_data[HEIGHT_REG_W-1:0];
						col_q    <= '0;
						row_q    <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		cmd              = '0;
		cmd.capture      = accept && !ignore;
		cmd.drain        = drain_pos;
		cmd.step         = (state_q == ST_STEP);
		cmd.pre          = pre_q;
		cmd.top_refl     = top_q;
		cmd.bot_refl     = bot_q;
		cmd.left_refl    = left_q;
		cmd.prewitt      = (kernel_q == KERNEL_PREWITT);
		cmd.square       = (state_q == ST_MUL);
		cmd.sum          = (state_q == ST_SUM);
		cmd.root         = (state_q == ST_ROOT);
		cmd.root_bit     = bit_q;
		cmd.load_out     = (state_q == ST_DONE) && sts.out_free;
		cmd.end_of_row   = eor_q;
		cmd.end_of_frame = eof_q;
	end

	assign col = col_q;

endmodule

// ===== rtl/core/spgm_datapath.sv =====
`timescale 1ns / 1ps
// datapath: line stores, 3x3 window, kernel sums, squares, iterative root, output register
module spgm_datapath import spgm_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	localparam int COL_W = $clog2(MAX_WIDTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PIXEL_W-1:0] pixel,
	input  logic [COL_W-1:0]   col,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	output logic               result_valid,
	input  logic               result_ready,
	output out_item_t          result
);

	logic [PIXEL_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIXEL_W-1:0] lower_mem [MAX_WIDTH];

	logic [PIXEL_W-1:0]       upper_rd_q;
	logic [PIXEL_W-1:0]       lower_rd_q;
	logic [PIXEL_W-1:0]       px_q;
	logic [COL_W-1:0]         addr_q;
	logic [PIXEL_W-1:0]       win_q [3][3];
	logic signed [GRAD_W-1:0] gx_q;
	logic signed [GRAD_W-1:0] gy_q;
	logic [SQ_W-1:0]          sqx_q;
	logic [SQ_W-1:0]          sqy_q;
	logic [SUM_W-1:0]         sum_q;
	logic [PIXEL_W-1:0]       root_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic [PIXEL_W-1:0]         win_sh [3][3];
	logic [PIXEL_W-1:0]         lcol [3];
	logic [PIXEL_W-1:0]         ccol [3];
	logic [PIXEL_W-1:0]         rcol [3];
	logic [PIXEL_W-1:0]         nb [3][3];
	logic signed [GRAD_W-1:0]   gx;
	logic signed [GRAD_W-1:0]   gy;
	logic signed [2*GRAD_W-1:0] gx_sq;
	logic signed [2*GRAD_W-1:0] gy_sq;
	logic [PIXEL_W-1:0]         trial;
	logic [2*PIXEL_W-1:0]       trial_sq;
	logic [2*PIXEL_W:0]         round_lim;
	logic [PIXEL_W-1:0]         mag;

	function automatic logic [GRAD_W-2:0] tap_sum(
		input logic [PIXEL_W-1:0] a,
		input logic [PIXEL_W-1:0] b,
		input logic [PIXEL_W-1:0] c,
		input logic               prewitt
	);
		logic [GRAD_W-2:0] mid;
		mid = prewitt ? (GRAD_W-1)'(b) : (GRAD_W-1)'({b, 1'b0});
		return (GRAD_W-1)'(a) + mid + (GRAD_W-1)'(c);
	endfunction

	// line stores, read on capture, written back on step
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			upper_rd_q <= upper_mem[col];
			lower_rd_q <= lower_mem[col];
			addr_q     <= col;
			px_q       <= cmd.drain ? '0 : pixel;
		end
		if (cmd.step) begin
			upper_mem[addr_q] <= lower_rd_q;
			lower_mem[addr_q] <= px_q;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_sh[r][0] = win_q[r][1];
			win_sh[r][1] = win_q[r][2];
		end
		win_sh[0][2] = upper_rd_q;
		win_sh[1][2] = lower_rd_q;
		win_sh[2][2] = px_q;
	end

	// column pick with right or left reflection, then row pick with top or bottom reflection
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			lcol[r] = cmd.pre ? win_q[r][1] : (cmd.left_refl ? win_sh[r][2] : win_sh[r][0]);
			ccol[r] = cmd.pre ? win_q[r][2] : win_sh[r][1];
			rcol[r] = cmd.pre ? win_q[r][1] : win_sh[r][2];
		end
		nb[0][0] = cmd.top_refl ? lcol[2] : lcol[0];
		nb[0][1] = cmd.top_refl ? ccol[2] : ccol[0];
		nb[0][2] = cmd.top_refl ? rcol[2] : rcol[0];
		nb[1][0] = lcol[1];
		nb[1][1] = ccol[1];
		nb[1][2] = rcol[1];
		nb[2][0] = cmd.bot_refl ? lcol[0] : lcol[2];
		nb[2][1] = cmd.bot_refl ? ccol[0] : ccol[2];
		nb[2][2] = cmd.bot_refl ? rcol[0] : rcol[2];
		gx = signed'({1'b0, tap_sum(nb[2][0], nb[2][1], nb[2][2], cmd.prewitt)})
			- signed'({1'b0, tap_sum(nb[0][0], nb[0][1], nb[0][2], cmd.prewitt)});
		gy = signed'({1'b0, tap_sum(nb[0][2], nb[1][2], nb[2][2], cmd.prewitt)})
			- signed'({1'b0, tap_sum(nb[0][0], nb[1][0], nb[2][0], cmd.prewitt)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (cmd.step) begin
			win_q <= win_sh;
		end
	end

	assign gx_sq    = gx_q * gx_q;
	assign gy_sq    = gy_q * gy_q;
	assign trial    = root_q | (PIXEL_W'(1) << cmd.root_bit);
	assign trial_sq = (2*PIXEL_W)'(trial) * (2*PIXEL_W)'(trial);
	assign round_lim = (2*PIXEL_W+1)'(root_q) * (2*PIXEL_W+1)'(root_q)
		+ (2*PIXEL_W+1)'(root_q);

	always_comb begin
		if (sum_q > SAT_LIMIT) begin
			mag = '1;
		end else if (sum_q > SUM_W'(round_lim)) begin
			mag = root_q + 1'b1;
		end else begin
			mag = root_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			gx_q <= gx;
			gy_q <= gy;
		end
		if (cmd.square) begin
			sqx_q <= gx_sq[SQ_W-1:0];
			sqy_q <= gy_sq[SQ_W-1:0];
		end
		if (cmd.sum) begin
			sum_q  <= {1'b0, sqx_q} + {1'b0, sqy_q};
			root_q <= '0;
		end else if (cmd.root && (SUM_W'(trial_sq) <= sum_q)) begin
			root_q <= trial;
		end
		if (cmd.load_out) begin
			out_q.magnitude    <= mag;
			out_q.end_of_row   <= cmd.end_of_row;
			out_q.end_of_frame <= cmd.end_of_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== rtl/core/sobel_prewitt_gradient_magnitude_unit.sv =====
`timescale 1ns / 1ps
// top level of the 3x3 Sobel / Prewitt gradient magnitude unit
// Takes 8-bit grey pixels in raster order and returns the rounded gradient magnitude,
// saturated to 255, with reflect-101 borders; results trail the input by one row plus
// one pixel, so W + 1 drain requests after the last pixel flush the frame. A request that
// produces a result occupies the unit for one line-store read, one window update, one
// square stage, one sum stage, eight steps of the bit-serial square root and one rounding
// and output step, which waits for a free output register; a request that produces no
// result takes the read and window update, and a drain request before the frame is
// complete is dropped. The output register lets the next request in while a result waits.
// Writing image_width or image_height restarts the frame; kernel_select applies at once.
module sobel_prewitt_gradient_magnitude_unit import spgm_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  in_item_t               item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output out_item_t              result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [COL_W-1:0] col;

	spgm_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_mode  (item.mode),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.col        (col),
		.cmd        (cmd),
		.sts        (sts)
	);

	spgm_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel        (item.pixel),
		.col          (col),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== rtl/core/spgm_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the gradient magnitude unit and its bind
`include "sobel_prewitt_gradient_magnitude_unit_assert.svh"
module spgm_checker import spgm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_ready,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result
);

	`SPGM_ASSERT_IMPLY(a_eof_on_eor, result_valid, !result.end_of_frame || result.end_of_row)
	`SPGM_ASSERT_NEXT(a_stall_hold, result_valid && !result_ready, result_valid && $stable(result))
	`SPGM_ASSERT_IMPLY(a_ready_drop_on_accept, $fell(item_ready), $past(item_valid))
	`SPGM_ASSERT_IMPLY(a_result_while_busy, $rose(result_valid), !$past(item_ready))

endmodule

bind sobel_prewitt_gradient_magnitude_unit spgm_checker u_spgm_checker (.*);
